[hw/rtl/rpu_pkg.sv]
// ----------------------------------------------------------------------------
// rpu_pkg
// Shared constants, codes and types of the readout packet unpacker.
// ----------------------------------------------------------------------------
package rpu_pkg;

   localparam int NUM_CARDS        = 20;
   localparam int SLOTS_PER_CARD   = 6;
   localparam int MAX_PACKET_WORDS = 4096;

   localparam int CELL_COUNT   = NUM_CARDS * SLOTS_PER_CARD;
   localparam int CELL_ADDR_W  = $clog2(CELL_COUNT);
   localparam int MISC_COUNT   = 15;
   localparam int MISC_ADDR_W  = 4;
   localparam int VALUE_W      = 20;
   localparam int CELL_VALUE_W = 16;
   localparam int WORDS_W      = 12;

   localparam int HEADER_WORDS = 5;
   localparam int USER_BASE    = 5;
   localparam int CAPTURE_LEN  = 10;
   localparam int PARITY_SLOT  = 13;
   localparam int CAP_INT      = (MAX_PACKET_WORDS > 4095) ? 4095 : MAX_PACKET_WORDS;

   localparam logic [WORDS_W-1:0] WORD_CAP   = WORDS_W'(CAP_INT);
   localparam logic [7:0]         USER_MARKER = 8'h81;

   typedef enum logic [1:0] {
      REQ_WORD = 2'd0,
      REQ_CELL = 2'd1,
      REQ_MISC = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      RES_END  = 2'd0,
      RES_CELL = 2'd1,
      RES_MISC = 2'd2
   } result_kind_type;

   typedef enum logic [1:0] {
      PAR_MATCH     = 2'd0,
      PAR_MISMATCH  = 2'd1,
      PAR_NO_MARKER = 2'd2
   } parity_status_type;

   typedef struct packed {
      logic                   en;
      logic [CELL_ADDR_W-1:0] addr;
      logic [VALUE_W-1:0]     data;
   } cell_wr_type;

   typedef struct packed {
      parity_status_type  status;
      logic [VALUE_W-1:0] parity;
      logic [WORDS_W-1:0] words;
   } end_info_type;

   function automatic logic cell_in_range(input logic [7:0] card, input logic [2:0] slot);
      return (32'(card) < NUM_CARDS) && (32'(slot) < SLOTS_PER_CARD);
   endfunction

   function automatic logic [CELL_ADDR_W-1:0] cell_addr(input logic [7:0] card,
                                                         input logic [2:0] slot);
      logic [10:0] full;
      full = 11'(card) * 11'(SLOTS_PER_CARD) + 11'(slot);
      return full[CELL_ADDR_W-1:0];
   endfunction

endpackage

[hw/rtl/roc_packet_unpack_parity.sv]
// ----------------------------------------------------------------------------
// roc_packet_unpack_parity
// Readout packet unpacker with parity check and cell / misc word readback.
// ----------------------------------------------------------------------------
// One beat is taken per clock while req_stall is low, packet words and reads
// alike, in any mix. A result (end-of-packet status, cell value or misc word)
// passes through stage one, beside the registered read port of the cell RAM,
// and then the output register. Cell values live in a 120-entry RAM; a
// per-entry written bit in flops is cleared at the first word of a packet, so
// no clearing pass is needed after reset or between packets.
// ----------------------------------------------------------------------------
module roc_packet_unpack_parity (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_packet_word,
   input  logic        req_last_word,
   input  logic [7:0]  req_card_index,
   input  logic [2:0]  req_slot_index,
   input  logic [3:0]  req_misc_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [19:0] rsp_read_value,
   output logic [1:0]  rsp_parity_status,
   output logic [19:0] rsp_computed_parity,
   output logic [11:0] rsp_words_seen
);
   import rpu_pkg::*;

   req_kind_type         kind;
   logic                 accept;
   logic                 word_accept;
   logic                 makes_result;
   logic                 out_free;

   cell_wr_type          cell_wr;
   logic                 cell_hit;
   logic [VALUE_W-1:0]   misc_value;
   end_info_type         end_info;
   logic [VALUE_W-1:0]   ram_data;

   logic                 s1_valid_ff, s1_valid_in;
   result_kind_type      s1_kind_ff;
   logic [VALUE_W-1:0]   s1_value_ff;
   logic                 s1_hit_ff;
   end_info_type         s1_end_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   result_kind_type      rsp_kind_ff;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   end_info_type         rsp_end_ff;

   assign kind        = req_kind_type'(req_type);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !out_free;
   assign accept      = req_valid && !req_stall;
   assign word_accept = accept && (kind == REQ_WORD);

   always_comb begin
      case (kind)
         REQ_WORD: makes_result = req_last_word;
         REQ_CELL: makes_result = 1'b1;
         REQ_MISC: makes_result = 1'b1;
         default:  makes_result = 1'b0;
      endcase
   end

   rpu_unpack u_unpack (
      .clock       (clock),
      .reset       (reset),
      .word_accept (word_accept),
      .packet_word (req_packet_word),
      .last_word   (req_last_word),
      .card_index  (req_card_index),
      .slot_index  (req_slot_index),
      .misc_index  (req_misc_index),
      .cell_wr     (cell_wr),
      .cell_hit    (cell_hit),
      .misc_value  (misc_value),
      .end_info    (end_info)
   );

   rpu_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CELL_COUNT)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_wr.en),
      .wr_addr (cell_wr.addr),
      .wr_data (cell_wr.data),
      .rd_en   (accept && (kind == REQ_CELL)),
      .rd_addr (cell_addr(req_card_index, req_slot_index)),
      .rd_data (ram_data)
   );

   always_comb begin
      if (accept && makes_result) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
      if (s1_kind_ff == RES_CELL) begin
         rsp_value_in = s1_hit_ff ? VALUE_W'(ram_data[CELL_VALUE_W-1:0]) : '0;
      end else begin
         rsp_value_in = s1_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && makes_result) begin
         s1_kind_ff  <= result_kind_type'(req_type);
         s1_value_ff <= (kind == REQ_MISC) ? misc_value : '0;
         s1_hit_ff   <= cell_hit;
         s1_end_ff   <= (kind == REQ_WORD) ? end_info : '0;
      end
      if (out_free && s1_valid_ff) begin
         rsp_kind_ff  <= s1_kind_ff;
         rsp_value_ff <= rsp_value_in;
         rsp_end_ff   <= s1_end_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_read_value      = rsp_value_ff;
   assign rsp_parity_status   = rsp_end_ff.status;
   assign rsp_computed_parity = rsp_end_ff.parity;
   assign rsp_words_seen      = rsp_end_ff.words;

   a_result_enters: assert property (@(posedge clock) disable iff (reset)
      accept && makes_result |=> s1_valid_ff)
      else $error("result beat lost at stage one");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_kind_ff))
      else $error("stage one changed while blocked");

   a_cell_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == RES_CELL |-> rsp_value_ff[VALUE_W-1:CELL_VALUE_W] == '0)
      else $error("cell value wider than 16 bits");

endmodule

[hw/rtl/rpu_ram.sv]
// ----------------------------------------------------------------------------
// rpu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpu_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 120
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/rpu_unpack.sv]
// ----------------------------------------------------------------------------
// rpu_unpack
// Packet word decode: header and user word capture, cell written bits,
// running parity, word count and end-of-packet status.
// ----------------------------------------------------------------------------
module rpu_unpack (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        word_accept,
   input  logic [31:0]                 packet_word,
   input  logic                        last_word,
   input  logic [7:0]                  card_index,
   input  logic [2:0]                  slot_index,
   input  logic [3:0]                  misc_index,
   output rpu_pkg::cell_wr_type        cell_wr,
   output logic                        cell_hit,
   output logic [rpu_pkg::VALUE_W-1:0] misc_value,
   output rpu_pkg::end_info_type       end_info
);
   import rpu_pkg::*;

   logic [WORDS_W-1:0]     pos_ff, pos_in;
   logic                   done_ff, done_in;
   logic                   seen_ff, seen_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic [VALUE_W-1:0]     acc_ff, acc_in;
   logic [VALUE_W-1:0]     d0_ff, d0_in;
   logic [VALUE_W-1:0]     d1_ff, d1_in;
   logic [VALUE_W-1:0]     misc_ff [MISC_COUNT];
   logic [VALUE_W-1:0]     misc_in [MISC_COUNT];
   logic [CELL_COUNT-1:0]  written_ff, written_in;

   logic [VALUE_W-1:0]     low;
   logic [VALUE_W-1:0]     parity;
   logic                   first;
   logic [WORDS_W:0]       count;

   always_comb begin
      low     = packet_word[VALUE_W-1:0];
      first   = (pos_ff == '0);
      pos_in  = pos_ff;
      done_in = done_ff;
      seen_in = seen_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      d0_in   = d0_ff;
      d1_in   = d1_ff;
      misc_in = misc_ff;
      written_in = written_ff;
      cell_wr = '0;
      parity  = '0;
      if (word_accept) begin
         if (first) begin
            done_in    = 1'b0;
            seen_in    = 1'b0;
            cnt_in     = '0;
            acc_in     = '0;
            d0_in      = '0;
            d1_in      = '0;
            misc_in    = '{default: '0};
            written_in = '0;
         end
         if (pos_ff < WORDS_W'(HEADER_WORDS)) begin
            misc_in[pos_ff[MISC_ADDR_W-1:0]] = low;
         end else begin
            if (!done_in) begin
               if (packet_word[31]) begin
                  done_in = 1'b1;
               end else if (cell_in_range(packet_word[31:24], packet_word[22:20])) begin
                  cell_wr.en   = 1'b1;
                  cell_wr.addr = cell_addr(packet_word[31:24], packet_word[22:20]);
                  cell_wr.data = low;
                  written_in[cell_wr.addr] = 1'b1;
               end
            end
            if (!seen_in && packet_word[31:24] == USER_MARKER) begin
               seen_in = 1'b1;
            end
            if (seen_in && cnt_in < 4'(CAPTURE_LEN)) begin
               misc_in[MISC_ADDR_W'(USER_BASE) + cnt_in] = low;
               cnt_in = cnt_in + 4'd1;
            end
         end
         if (pos_ff >= WORDS_W'(2)) begin
            acc_in = acc_in ^ d1_ff;
         end
         if (first) begin
            parity = low;
         end else if (pos_ff == WORDS_W'(1)) begin
            parity = d0_ff;
         end else begin
            parity = acc_in;
         end
         d1_in = d0_in;
         d0_in = low;
         if (last_word) begin
            pos_in = '0;
         end else if (pos_ff < WORD_CAP) begin
            pos_in = pos_ff + WORDS_W'(1);
         end
      end
   end

   always_comb begin
      count = {1'b0, pos_ff} + (WORDS_W+1)'(1);
      end_info.parity = parity;
      end_info.words  = (count > {1'b0, WORD_CAP}) ? WORD_CAP : count[WORDS_W-1:0];
      if (!seen_in) begin
         end_info.status = PAR_NO_MARKER;
      end else if (parity == misc_in[PARITY_SLOT]) begin
         end_info.status = PAR_MATCH;
      end else begin
         end_info.status = PAR_MISMATCH;
      end
   end

   assign cell_hit   = cell_in_range(card_index, slot_index) &&
                       written_ff[cell_addr(card_index, slot_index)];
   assign misc_value = (32'(misc_index) < MISC_COUNT) ? misc_ff[misc_index] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         done_ff    <= 1'b0;
         seen_ff    <= 1'b0;
         cnt_ff     <= '0;
         acc_ff     <= '0;
         d0_ff      <= '0;
         d1_ff      <= '0;
         misc_ff    <= '{default: '0};
         written_ff <= '0;
      end else begin
         pos_ff     <= pos_in;
         done_ff    <= done_in;
         seen_ff    <= seen_in;
         cnt_ff     <= cnt_in;
         acc_ff     <= acc_in;
         d0_ff      <= d0_in;
         d1_ff      <= d1_in;
         misc_ff    <= misc_in;
         written_ff <= written_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'(CAPTURE_LEN))
      else $error("user capture count overran");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= WORD_CAP)
      else $error("word position beyond cap");

   a_cnt_needs_marker: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 |-> seen_ff)
      else $error("user words captured without marker");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the readout packet unpacker with parity check.
// Packets (well-formed, truncated, markerless, noisy) are interleaved with
// cell and misc reads. Each taken beat is run through a local unpacker model,
// and every result beat is compared field by field.
// Sender gaps and receiver stalls vary per phase.
// ----------------------------------------------------------------------------
module tb_top;
   import rpu_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int PHASE_BEATS = 430;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] word;
      logic        last;
      logic [7:0]  card;
      logic [2:0]  slot;
      logic [3:0]  misc;
   } beat_type;

   typedef struct {
      result_kind_type   kind;
      logic [19:0]       value;
      parity_status_type status;
      logic [19:0]       parity;
      logic [11:0]       words;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_WORD;
   logic [31:0] req_packet_word = '0;
   logic        req_last_word = 1'b0;
   logic [7:0]  req_card_index = '0;
   logic [2:0]  req_slot_index = '0;
   logic [3:0]  req_misc_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [19:0] rsp_read_value;
   logic [1:0]  rsp_parity_status;
   logic [19:0] rsp_computed_parity;
   logic [11:0] rsp_words_seen;

   beat_type    beats_to_send[$];
   outcome_type due_outcomes[$];
   logic [31:0] pkt_words[$];
   beat_type    on_wire;
   int          beats_made = 0;
   int          mismatches = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          idle_by_phase[4] = '{0, 70, 0, 15};
   int          stall_by_phase[4] = '{0, 0, 70, 15};

   // unpacker model state
   logic [19:0] cell_val [CELL_COUNT];
   logic        cell_set [CELL_COUNT];
   logic [19:0] misc_val [MISC_COUNT];
   int          wpos;
   logic        data_done;
   logic        marker_seen;
   int          user_cnt;
   logic [19:0] xor_acc;
   logic [19:0] lag0;
   logic [19:0] lag1;

   roc_packet_unpack_parity uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_packet_word     (req_packet_word),
      .req_last_word       (req_last_word),
      .req_card_index      (req_card_index),
      .req_slot_index      (req_slot_index),
      .req_misc_index      (req_misc_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_read_value      (rsp_read_value),
      .rsp_parity_status   (rsp_parity_status),
      .rsp_computed_parity (rsp_computed_parity),
      .rsp_words_seen      (rsp_words_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_unpacker();
      for (int i = 0; i < CELL_COUNT; i++) begin
         cell_val[i] = '0;
         cell_set[i] = 1'b0;
      end
      for (int i = 0; i < MISC_COUNT; i++) misc_val[i] = '0;
      wpos = 0;
      data_done = 1'b0;
      marker_seen = 1'b0;
      user_cnt = 0;
      xor_acc = '0;
      lag0 = '0;
      lag1 = '0;
   endfunction

   function automatic void unpack_beat(input beat_type b);
      outcome_type r;
      logic [19:0] low;
      logic [19:0] par;
      int          card;
      int          slot;
      r.kind = RES_CELL;
      r.value = '0;
      r.status = PAR_MATCH;
      r.parity = '0;
      r.words = '0;
      case (b.kind)
         REQ_WORD: begin
            low = b.word[19:0];
            if (wpos == 0) clear_unpacker();
            if (wpos < HEADER_WORDS) begin
               misc_val[wpos] = low;
            end else begin
               if (!data_done) begin
                  card = b.word[31:24];
                  slot = b.word[22:20];
                  if (b.word[31]) begin
                     data_done = 1'b1;
                  end else if (slot < SLOTS_PER_CARD && card < NUM_CARDS) begin
                     cell_val[card * SLOTS_PER_CARD + slot] = low;
                     cell_set[card * SLOTS_PER_CARD + slot] = 1'b1;
                  end
               end
               if (!marker_seen && b.word[31:24] == USER_MARKER) marker_seen = 1'b1;
               if (marker_seen && user_cnt < CAPTURE_LEN) begin
                  misc_val[USER_BASE + user_cnt] = low;
                  user_cnt++;
               end
            end
            if (wpos >= 2) xor_acc ^= lag1;
            par = (wpos == 0) ? low : (wpos == 1) ? lag0 : xor_acc;
            lag1 = lag0;
            lag0 = low;
            if (!b.last) begin
               if (wpos < CAP_INT) wpos++;
            end else begin
               r.kind = RES_END;
               r.status = !marker_seen ? PAR_NO_MARKER :
                          (par == misc_val[PARITY_SLOT]) ? PAR_MATCH : PAR_MISMATCH;
               r.parity = par;
               r.words = 12'((wpos + 1 > CAP_INT) ? CAP_INT : wpos + 1);
               wpos = 0;
               due_outcomes.push_back(r);
            end
         end
         REQ_CELL: begin
            card = b.card;
            slot = b.slot;
            if (card < NUM_CARDS && slot < SLOTS_PER_CARD)
               if (cell_set[card * SLOTS_PER_CARD + slot])
                  r.value = {4'h0, cell_val[card * SLOTS_PER_CARD + slot][15:0]};
            due_outcomes.push_back(r);
         end
         REQ_MISC: begin
            r.kind = RES_MISC;
            if (b.misc < MISC_COUNT) r.value = misc_val[b.misc];
            due_outcomes.push_back(r);
         end
         default: ;
      endcase
   endfunction

   task automatic push_beat(input beat_type b);
      beats_to_send.push_back(b);
      if (b.kind != REQ_UNUSED) beats_made++;
   endtask

   task automatic send_word(input logic [31:0] w, input logic last);
      beat_type b;
      b.kind = REQ_WORD;
      b.word = w;
      b.last = last;
      b.card = 8'($urandom);
      b.slot = 3'($urandom);
      b.misc = 4'($urandom);
      push_beat(b);
   endtask

   task automatic send_read(input logic [1:0] kind, input logic [7:0] card,
                            input logic [2:0] slot, input logic [3:0] misc);
      beat_type b;
      b.kind = kind;
      b.word = $urandom;
      b.last = 1'($urandom);
      b.card = card;
      b.slot = slot;
      b.misc = misc;
      push_beat(b);
   endtask

   task automatic send_any_read();
      if ($urandom_range(1) == 1)
         send_read(REQ_CELL,
                   ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(NUM_CARDS + 1)),
                   3'($urandom), 4'($urandom));
      else
         send_read(REQ_MISC, 8'($urandom), 3'($urandom), 4'($urandom));
   endtask

   task automatic send_ignored();
      send_read(REQ_UNUSED, 8'($urandom), 3'($urandom), 4'($urandom));
   endtask

   task automatic send_packet(input int read_pct);
      for (int i = 0; i < pkt_words.size(); i++) begin
         if ($urandom_range(99) < read_pct) send_any_read();
         send_word(pkt_words[i], i == pkt_words.size() - 1);
      end
   endtask

   // marker, seven user words, parity word, summary word
   task automatic add_user_block(input logic good);
      logic [19:0] acc;
      pkt_words.push_back({USER_MARKER, 24'($urandom)});
      repeat (7) pkt_words.push_back($urandom);
      acc = '0;
      foreach (pkt_words[i]) acc ^= pkt_words[i][19:0];
      pkt_words.push_back(good ? {12'($urandom), acc} : $urandom);
      pkt_words.push_back($urandom);
   endtask

   task automatic queue_good_packet();
      int pick;
      pkt_words = {};
      repeat (HEADER_WORDS) pkt_words.push_back($urandom);
      repeat ($urandom_range(12))
         pkt_words.push_back({1'b0,
                              ($urandom_range(9) == 0) ? 7'($urandom)
                                                       : 7'($urandom_range(NUM_CARDS + 3)),
                              1'($urandom), 3'($urandom), 20'($urandom)});
      pick = $urandom_range(99);
      if (pick < 85) begin
         add_user_block(pick < 68);
      end else begin
         pkt_words.push_back({1'b1, 31'($urandom)});
         repeat ($urandom_range(10)) pkt_words.push_back($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 10)
         pkt_words = pkt_words[0:$urandom_range(pkt_words.size() - 1)];
      else if (pick < 20)
         repeat ($urandom_range(1, 3)) pkt_words.push_back($urandom);
      send_packet(15);
   endtask

   task automatic wait_drained();
      while (beats_to_send.size() != 0 || req_valid || due_outcomes.size() != 0)
         @(negedge clock);
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) unpack_beat(on_wire);
         if (!req_valid || !req_stall) begin
            if (beats_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
               on_wire = beats_to_send.pop_front();
               req_valid <= 1'b1;
               req_type <= on_wire.kind;
               req_packet_word <= on_wire.word;
               req_last_word <= on_wire.last;
               req_card_index <= on_wire.card;
               req_slot_index <= on_wire.slot;
               req_misc_index <= on_wire.misc;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      outcome_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (due_outcomes.size() == 0) begin
               $display("%0t: unexpected result beat: kind %0h value %0h", $time,
                        rsp_result_kind, rsp_read_value);
               mismatches++;
            end else begin
               want = due_outcomes.pop_front();
               check_field("result_kind", want.kind, rsp_result_kind);
               check_field("read_value", want.value, rsp_read_value);
               check_field("parity_status", want.status, rsp_parity_status);
               check_field("computed_parity", want.parity, rsp_computed_parity);
               check_field("words_seen", want.words, rsp_words_seen);
            end
         end
      end
   end

   initial begin
      int target;
      int pick;
      clear_unpacker();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idle_by_phase[ph];
         stall_pct = stall_by_phase[ph];
         if (ph == 0) begin
            send_read(REQ_CELL, 8'd0, 3'd0, 4'd0);
            send_read(REQ_MISC, 8'hFF, 3'd7, 4'd14);
            send_ignored();
            send_word(32'hFFFF_FFFF, 1'b1);
            send_word(32'h0000_0000, 1'b0);
            send_word(32'h8100_0000, 1'b1);
            pkt_words = {32'h81FF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom,
                         {8'(NUM_CARDS - 1), 1'b0, 3'(SLOTS_PER_CARD - 1), 20'hFFFFF},
                         {8'(NUM_CARDS), 1'b1, 3'd0, 20'h12345},
                         {8'd0, 1'b0, 3'(SLOTS_PER_CARD), 20'h00001}};
            add_user_block(1'b1);
            send_packet(0);
            send_read(REQ_CELL, 8'(NUM_CARDS - 1), 3'(SLOTS_PER_CARD - 1), 4'd15);
            send_read(REQ_CELL, 8'(NUM_CARDS), 3'd0, 4'd0);
            send_read(REQ_MISC, 8'd0, 3'd0, 4'(PARITY_SLOT));
            send_read(REQ_MISC, 8'hFF, 3'd7, 4'd15);
         end
         target = beats_made + PHASE_BEATS;
         while (beats_made < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               queue_good_packet();
            end else if (pick < 80) begin
               pkt_words = {};
               repeat ($urandom_range(1, 24)) pkt_words.push_back($urandom);
               send_packet(10);
            end else if (pick < 95) begin
               repeat ($urandom_range(1, 6)) send_any_read();
            end else begin
               send_ignored();
            end
         end
         wait_drained();
      end

      repeat (16) @(posedge clock);
      if (mismatches == 0 && due_outcomes.size() == 0 && beats_to_send.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #5000000;
      $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
hw/rtl/rpu_pkg.sv
hw/rtl/rpu_ram.sv
hw/rtl/rpu_unpack.sv
hw/rtl/roc_packet_unpack_parity.sv
tb/tb_top.sv
